// File: design/rdpd_pkg.sv
// ----------------------------------------------------------------------------
// rdpd_pkg
// Shared types, codes and constants of the rotary dial pulse decoder.
// ----------------------------------------------------------------------------
`default_nettype none

package rdpd_pkg;

   localparam int unsigned MAX_DIGITS_DEF = 32;

   localparam int unsigned CMD_W    = 2;
   localparam int unsigned CSR_IDX_W = 2;
   localparam int unsigned CSR_W    = 16;
   localparam int unsigned KIND_W   = 3;
   localparam int unsigned DIGIT_W  = 4;
   localparam int unsigned LEN_W    = 6;
   localparam int unsigned PULSE_W  = 5;
   localparam int unsigned TMR_W    = 2;

   // request commands
   localparam logic [CMD_W-1:0] CMD_TICK = 2'd0;
   localparam logic [CMD_W-1:0] CMD_DIAL = 2'd1;
   localparam logic [CMD_W-1:0] CMD_HOOK = 2'd2;

   // configuration register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_DEBOUNCE = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_COMMIT   = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_DIGIT_TO = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_END_TO   = 2'd3;

   localparam logic [CSR_W-1:0] DEBOUNCE_RST = 16'd20;
   localparam logic [CSR_W-1:0] COMMIT_RST   = 16'd200;
   localparam logic [CSR_W-1:0] DIGIT_TO_RST = 16'd250;
   localparam logic [CSR_W-1:0] END_TO_RST   = 16'd2000;

   // result kinds
   localparam logic [KIND_W-1:0] EVT_HOOK   = 3'd0;
   localparam logic [KIND_W-1:0] EVT_START  = 3'd1;
   localparam logic [KIND_W-1:0] EVT_DIGIT  = 3'd2;
   localparam logic [KIND_W-1:0] EVT_NUMBER = 3'd3;
   localparam logic [KIND_W-1:0] EVT_CANCEL = 3'd4;

   // countdown timer kinds
   localparam logic [TMR_W-1:0] TMR_NONE  = 2'd0;
   localparam logic [TMR_W-1:0] TMR_DIGIT = 2'd1;
   localparam logic [TMR_W-1:0] TMR_END   = 2'd2;

   localparam logic [PULSE_W-1:0] NO_PULSE  = 5'd31;
   localparam logic [PULSE_W-1:0] PULSE_SAT = 5'd15;
   localparam logic [PULSE_W-1:0] PULSE_TEN = 5'd10;
   localparam logic [CSR_W-1:0]   MS_MAX    = 16'hFFFF;

   typedef struct packed {
      logic exec;         // commit the accepted request
      logic cancel_load;  // load the cancel result
      logic rd_issue;     // read the next stored digit
      logic rd_load;      // load the read digit as a result
   } rdpd_cmd_type;

   typedef struct packed {
      logic has_first;
      logic cancel;
      logic start_read;
      logic rd_empty;
      logic rd_last;
   } rdpd_sts_type;

   function automatic int unsigned idx_width(int unsigned n);
      return (n > 1) ? $clog2(n) : 1;
   endfunction

endpackage

`default_nettype wire

// File: design/rotary_dial_pulse_decoder_unit.sv
// Output: a request's first result enters the output register at the edge that accepts it.
// Throughput: one request per cycle while the output register is free and no cancel or
// readout runs; a cancel holds off new requests until its result is loaded; an ended number
// is read via the registered digit store port and holds off new requests until read out.
// Reset: synchronous; clears control state and loads the default timings, no clearing pass.
// ----------------------------------------------------------------------------
// rotary_dial_pulse_decoder_unit
// Rotary dial decoder: debounces dial and hook edges, counts pulses into
// digits, stores the number and reads it back when dialing ends.
// ----------------------------------------------------------------------------
`default_nettype none

module rotary_dial_pulse_decoder_unit #(
   parameter int unsigned MAX_DIGITS = rdpd_pkg::MAX_DIGITS_DEF
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            csr_write,
   input  wire logic [rdpd_pkg::CSR_IDX_W-1:0]  csr_index,
   input  wire logic [rdpd_pkg::CSR_W-1:0]      csr_wdata,
   input  wire logic                            req_valid,
   output logic                                 req_ready,
   input  wire logic [rdpd_pkg::CMD_W-1:0]      req_command,
   input  wire logic                            req_pin_level,
   output logic                                 rsp_valid,
   input  wire logic                            rsp_ready,
   output logic      [rdpd_pkg::KIND_W-1:0]     rsp_event_kind,
   output logic      [rdpd_pkg::DIGIT_W-1:0]    rsp_digit,
   output logic                                 rsp_hook_level,
   output logic      [rdpd_pkg::LEN_W-1:0]      rsp_number_length,
   output logic                                 rsp_last_of_run
);
   import rdpd_pkg::*;

   rdpd_cmd_type cmd;
   rdpd_sts_type sts;

   rdpd_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   rdpd_dp #(
      .MAX_DIGITS (MAX_DIGITS)
   ) u_dp (
      .clock             (clock),
      .reset             (reset),
      .csr_write         (csr_write),
      .csr_index         (csr_index),
      .csr_wdata         (csr_wdata),
      .req_command       (req_command),
      .req_pin_level     (req_pin_level),
      .cmd               (cmd),
      .sts               (sts),
      .rsp_event_kind    (rsp_event_kind),
      .rsp_digit         (rsp_digit),
      .rsp_hook_level    (rsp_hook_level),
      .rsp_number_length (rsp_number_length),
      .rsp_last_of_run   (rsp_last_of_run)
   );

endmodule

`default_nettype wire

// File: design/rdpd_ram.sv
// ----------------------------------------------------------------------------
// rdpd_ram
// Generic single write, single read RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module rdpd_ram #(
   parameter int unsigned WIDTH = 4,
   parameter int unsigned DEPTH = 32
) (
   input  wire logic                                   clock,
   input  wire logic                                   wr_en,
   input  wire logic [rdpd_pkg::idx_width(DEPTH)-1:0]  wr_addr,
   input  wire logic [WIDTH-1:0]                       wr_data,
   input  wire logic                                   rd_en,
   input  wire logic [rdpd_pkg::idx_width(DEPTH)-1:0]  rd_addr,
   output logic      [WIDTH-1:0]                       rd_data
);
   import rdpd_pkg::*;

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// File: design/rdpd_ctrl.sv
// ----------------------------------------------------------------------------
// rdpd_ctrl
// Sequencer: request acceptance, second results and stored digit readout.
// ----------------------------------------------------------------------------
`default_nettype none

module rdpd_ctrl (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   req_valid,
   output logic                        req_ready,
   output logic                        rsp_valid,
   input  wire logic                   rsp_ready,
   input  wire rdpd_pkg::rdpd_sts_type sts,
   output rdpd_pkg::rdpd_cmd_type      cmd
);
   import rdpd_pkg::*;

   localparam logic [1:0] ST_IDLE    = 2'd0;
   localparam logic [1:0] ST_CANCEL  = 2'd1;
   localparam logic [1:0] ST_RD_ADDR = 2'd2;
   localparam logic [1:0] ST_RD_DATA = 2'd3;

   logic [1:0] state_ff, state_in;
   logic       rsp_valid_ff, rsp_valid_in;
   logic       out_free;
   logic       load;

   assign out_free = !rsp_valid_ff || rsp_ready;

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready = out_free;
            if (req_valid && out_free) begin
               cmd.exec = 1'b1;
               if (sts.cancel) begin
                  state_in = ST_CANCEL;
               end else if (sts.start_read) begin
                  state_in = ST_RD_ADDR;
               end
            end
         end
         ST_CANCEL: begin
            if (out_free) begin
               cmd.cancel_load = 1'b1;
               state_in = ST_IDLE;
            end
         end
         ST_RD_ADDR: begin
            if (sts.rd_empty) begin
               state_in = ST_IDLE;
            end else begin
               cmd.rd_issue = 1'b1;
               state_in = ST_RD_DATA;
            end
         end
         ST_RD_DATA: begin
            if (out_free) begin
               cmd.rd_load = 1'b1;
               state_in = sts.rd_last ? ST_IDLE : ST_RD_ADDR;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign load = (cmd.exec && sts.has_first) || cmd.cancel_load || cmd.rd_load;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

`default_nettype wire

// File: design/rdpd_dp.sv
// ----------------------------------------------------------------------------
// rdpd_dp
// Datapath: configuration, timers, pulse counting, digit store and results.
// ----------------------------------------------------------------------------
`default_nettype none

module rdpd_dp #(
   parameter int unsigned MAX_DIGITS = rdpd_pkg::MAX_DIGITS_DEF
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                csr_write,
   input  wire logic [rdpd_pkg::CSR_IDX_W-1:0]      csr_index,
   input  wire logic [rdpd_pkg::CSR_W-1:0]          csr_wdata,
   input  wire logic [rdpd_pkg::CMD_W-1:0]          req_command,
   input  wire logic                                req_pin_level,
   input  wire rdpd_pkg::rdpd_cmd_type              cmd,
   output rdpd_pkg::rdpd_sts_type                   sts,
   output logic      [rdpd_pkg::KIND_W-1:0]         rsp_event_kind,
   output logic      [rdpd_pkg::DIGIT_W-1:0]        rsp_digit,
   output logic                                     rsp_hook_level,
   output logic      [rdpd_pkg::LEN_W-1:0]          rsp_number_length,
   output logic                                     rsp_last_of_run
);
   import rdpd_pkg::*;

   localparam int unsigned ADDR_W = idx_width(MAX_DIGITS);
   localparam int unsigned CNT_W  = $clog2(MAX_DIGITS + 1);
   localparam int unsigned CMP_W  = CNT_W + 1;

   // configuration
   logic [CSR_W-1:0] debounce_ff, commit_ff, digit_to_ff, end_to_ff;

   // decoder state
   logic [CSR_W-1:0]   ms_ff, ms_in;
   logic               hook_off_ff, hook_off_in;
   logic               dialing_ff, dialing_in;
   logic [PULSE_W-1:0] pulse_ff, pulse_in;
   logic [CNT_W-1:0]   total_ff, total_in;
   logic [CSR_W-1:0]   countdown_ff, countdown_in;
   logic [TMR_W-1:0]   tkind_ff, tkind_in;

   // readout
   logic [ADDR_W-1:0]  rd_idx_ff;
   logic [CNT_W-1:0]   rd_len_ff;
   logic [DIGIT_W-1:0] rd_data;

   // result payload
   logic [KIND_W-1:0]  kind_ff;
   logic [DIGIT_W-1:0] digit_ff;
   logic               hook_ff;
   logic [LEN_W-1:0]   len_ff;
   logic               last_ff;

   logic               do_complete, emit_hook, emit_start, emit_digit;
   logic               start_read, cancel, store_wr;
   logic [DIGIT_W-1:0] pulse_digit;

   assign pulse_digit = (pulse_ff >= PULSE_TEN) ? '0 : pulse_ff[DIGIT_W-1:0];

   always_comb begin
      ms_in        = ms_ff;
      hook_off_in  = hook_off_ff;
      dialing_in   = dialing_ff;
      pulse_in     = pulse_ff;
      total_in     = total_ff;
      countdown_in = countdown_ff;
      tkind_in     = tkind_ff;
      do_complete  = 1'b0;
      emit_hook    = 1'b0;
      emit_start   = 1'b0;
      emit_digit   = 1'b0;
      start_read   = 1'b0;
      cancel       = 1'b0;
      store_wr     = 1'b0;

      unique case (req_command)
         CMD_TICK: begin
            if (ms_ff != MS_MAX) begin
               ms_in = ms_ff + 1'b1;
            end
            if (tkind_ff != TMR_NONE) begin
               if (countdown_ff > 16'd1) begin
                  countdown_in = countdown_ff - 1'b1;
               end else if (tkind_ff == TMR_DIGIT) begin
                  do_complete = 1'b1;
               end else begin
                  start_read = 1'b1;
               end
            end
         end
         CMD_DIAL, CMD_HOOK: begin
            ms_in = '0;
            if (ms_ff >= debounce_ff) begin
               if (req_command == CMD_HOOK) begin
                  hook_off_in = req_pin_level;
                  emit_hook   = 1'b1;
                  cancel      = !req_pin_level && (total_ff != '0);
               end else if (hook_off_ff) begin
                  if (req_pin_level) begin
                     if (!dialing_ff) begin
                        dialing_in = 1'b1;
                        emit_start = 1'b1;
                     end else begin
                        tkind_in     = TMR_NONE;
                        countdown_in = '0;
                        do_complete  = (ms_ff >= commit_ff) && (pulse_ff != NO_PULSE);
                     end
                  end else if (dialing_ff) begin
                     if (pulse_ff == NO_PULSE) begin
                        pulse_in = '0;
                     end else if (pulse_ff < PULSE_SAT) begin
                        pulse_in = pulse_ff + 1'b1;
                     end
                     tkind_in     = TMR_DIGIT;
                     countdown_in = digit_to_ff;
                  end
               end
            end
         end
         default: begin
         end
      endcase

      if (do_complete) begin
         tkind_in     = TMR_NONE;
         countdown_in = '0;
         if (pulse_ff != NO_PULSE) begin
            if (total_ff >= CNT_W'(MAX_DIGITS)) begin
               // store full: drop the digit, end the number
               start_read = 1'b1;
            end else begin
               emit_digit   = 1'b1;
               store_wr     = 1'b1;
               total_in     = total_ff + 1'b1;
               pulse_in     = NO_PULSE;
               tkind_in     = TMR_END;
               countdown_in = end_to_ff;
            end
         end
      end

      if (start_read || cancel) begin
         total_in     = '0;
         pulse_in     = NO_PULSE;
         dialing_in   = 1'b0;
         tkind_in     = TMR_NONE;
         countdown_in = '0;
      end
   end

   assign sts.has_first  = emit_hook || emit_start || emit_digit;
   assign sts.cancel     = cancel;
   assign sts.start_read = start_read;
   assign sts.rd_empty   = (rd_len_ff == '0);
   assign sts.rd_last    = (CMP_W'(rd_idx_ff) + CMP_W'(1)) == CMP_W'(rd_len_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         debounce_ff  <= DEBOUNCE_RST;
         commit_ff    <= COMMIT_RST;
         digit_to_ff  <= DIGIT_TO_RST;
         end_to_ff    <= END_TO_RST;
         ms_ff        <= '0;
         hook_off_ff  <= 1'b0;
         dialing_ff   <= 1'b0;
         pulse_ff     <= NO_PULSE;
         total_ff     <= '0;
         countdown_ff <= '0;
         tkind_ff     <= TMR_NONE;
         rd_idx_ff    <= '0;
         rd_len_ff    <= '0;
      end else begin
         if (csr_write) begin
            unique case (csr_index)
               CSR_DEBOUNCE: debounce_ff <= csr_wdata;
               CSR_COMMIT:   commit_ff   <= csr_wdata;
               CSR_DIGIT_TO: digit_to_ff <= csr_wdata;
               CSR_END_TO:   end_to_ff   <= csr_wdata;
               default: begin
               end
            endcase
         end
         if (cmd.exec) begin
            ms_ff        <= ms_in;
            hook_off_ff  <= hook_off_in;
            dialing_ff   <= dialing_in;
            pulse_ff     <= pulse_in;
            total_ff     <= total_in;
            countdown_ff <= countdown_in;
            tkind_ff     <= tkind_in;
            if (start_read) begin
               rd_idx_ff <= '0;
               rd_len_ff <= total_ff;
            end
         end
         if (cmd.rd_load) begin
            rd_idx_ff <= rd_idx_ff + 1'b1;
         end
      end
   end

   // result payload, loaded only when the output slot is free
   always_ff @(posedge clock) begin
      if (cmd.exec && sts.has_first) begin
         kind_ff  <= emit_hook ? EVT_HOOK : (emit_start ? EVT_START : EVT_DIGIT);
         digit_ff <= emit_digit ? pulse_digit : '0;
         hook_ff  <= emit_hook && req_pin_level;
         len_ff   <= '0;
         last_ff  <= !cancel;
      end else if (cmd.cancel_load) begin
         kind_ff  <= EVT_CANCEL;
         digit_ff <= '0;
         hook_ff  <= 1'b0;
         len_ff   <= '0;
         last_ff  <= 1'b1;
      end else if (cmd.rd_load) begin
         kind_ff  <= EVT_NUMBER;
         digit_ff <= rd_data;
         hook_ff  <= 1'b0;
         len_ff   <= LEN_W'(rd_len_ff);
         last_ff  <= sts.rd_last;
      end
   end

   rdpd_ram #(
      .WIDTH (DIGIT_W),
      .DEPTH (MAX_DIGITS)
   ) u_store (
      .clock   (clock),
      .wr_en   (cmd.exec && store_wr),
      .wr_addr (total_ff[ADDR_W-1:0]),
      .wr_data (pulse_digit),
      .rd_en   (cmd.rd_issue),
      .rd_addr (rd_idx_ff),
      .rd_data (rd_data)
   );

   assign rsp_event_kind    = kind_ff;
   assign rsp_digit         = digit_ff;
   assign rsp_hook_level    = hook_ff;
   assign rsp_number_length = len_ff;
   assign rsp_last_of_run   = last_ff;

endmodule

`default_nettype wire

// File: tb/rdpd_tb_pkg.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// rdpd_tb_pkg
// Result record and scoreboard for the rotary dial decoder testbench. The
// scoreboard predicts the decoder's events from each accepted request and
// compares the events that the block returns with the oldest prediction.
// ----------------------------------------------------------------------------

package rdpd_tb_pkg;

   import rdpd_pkg::*;

   typedef struct packed {
      logic [KIND_W-1:0]  kind;
      logic [DIGIT_W-1:0] digit;
      logic               hook;
      logic [LEN_W-1:0]   length;
      logic               last;
   } dial_event_t;

   class dial_scoreboard;
      logic [CSR_W-1:0]   debounce_ms, commit_ms, digit_wait_ms, end_wait_ms;
      logic [CSR_W-1:0]   idle_ms;
      logic               hook_off;
      logic               dialing;
      logic [PULSE_W-1:0] pulses;
      logic [LEN_W-1:0]   stored;
      logic [CSR_W-1:0]   countdown;
      logic [TMR_W-1:0]   timer;
      logic [DIGIT_W-1:0] digit_mem [MAX_DIGITS_DEF];
      dial_event_t        awaited_events [$];
      int                 n_checked;
      int                 n_failed;

      function new();
         debounce_ms   = DEBOUNCE_RST;
         commit_ms     = COMMIT_RST;
         digit_wait_ms = DIGIT_TO_RST;
         end_wait_ms   = END_TO_RST;
         idle_ms       = '0;
         hook_off      = 1'b0;
         countdown     = '0;
         timer         = TMR_NONE;
         foreach (digit_mem[i]) digit_mem[i] = '0;
         clear_number();
         n_checked = 0;
         n_failed  = 0;
      endfunction

      function void write_register(logic [CSR_IDX_W-1:0] idx, logic [CSR_W-1:0] value);
         case (idx)
            CSR_DEBOUNCE: debounce_ms   = value;
            CSR_COMMIT:   commit_ms     = value;
            CSR_DIGIT_TO: digit_wait_ms = value;
            CSR_END_TO:   end_wait_ms   = value;
            default: ;
         endcase
      endfunction

      function void push_event(logic [KIND_W-1:0] kind, logic [DIGIT_W-1:0] dig,
                               logic hook, logic [LEN_W-1:0] len);
         dial_event_t ev;
         ev.kind   = kind;
         ev.digit  = dig;
         ev.hook   = hook;
         ev.length = len;
         ev.last   = 1'b0;
         awaited_events.push_back(ev);
      endfunction

      function void clear_number();
         stored  = '0;
         pulses  = NO_PULSE;
         dialing = 1'b0;
      endfunction

      function void stop_timer();
         timer     = TMR_NONE;
         countdown = '0;
      endfunction

      function void read_out_number();
         int i;
         for (i = 0; i < stored; i++)
            push_event(EVT_NUMBER, digit_mem[i], 1'b0, stored);
         clear_number();
         stop_timer();
      endfunction

      function void finish_digit();
         logic [DIGIT_W-1:0] d;
         stop_timer();
         if (pulses == NO_PULSE) return;
         d = (pulses >= PULSE_TEN) ? '0 : pulses[DIGIT_W-1:0];
         // full store: drop the digit and end the number at once
         if (stored >= MAX_DIGITS_DEF) begin
            read_out_number();
            return;
         end
         push_event(EVT_DIGIT, d, 1'b0, '0);
         digit_mem[stored] = d;
         stored++;
         pulses    = NO_PULSE;
         timer     = TMR_END;
         countdown = end_wait_ms;
      endfunction

      function void tick();
         if (idle_ms != MS_MAX) idle_ms++;
         if (timer == TMR_NONE) return;
         // a timer loaded with zero runs out like one loaded with one
         if (countdown > 1) begin
            countdown--;
            return;
         end
         if (timer == TMR_DIGIT) finish_digit();
         else read_out_number();
      endfunction

      function void pin_edge(logic is_hook, logic level);
         logic [CSR_W-1:0] gap;
         gap     = idle_ms;
         idle_ms = '0;
         if (gap < debounce_ms) return;
         if (is_hook) begin
            hook_off = level;
            push_event(EVT_HOOK, '0, level, '0);
            // going on hook cancels only a number with stored digits
            if (!hook_off && stored != 0) begin
               stop_timer();
               clear_number();
               push_event(EVT_CANCEL, '0, 1'b0, '0);
            end
            return;
         end
         if (!hook_off) return;
         if (level) begin
            if (!dialing) begin
               dialing = 1'b1;
               push_event(EVT_START, '0, 1'b0, '0);
               return;
            end
            stop_timer();
            if (gap >= commit_ms && pulses != NO_PULSE) finish_digit();
            return;
         end
         if (dialing) begin
            if (pulses == NO_PULSE) pulses = '0;
            else if (pulses < PULSE_SAT) pulses++;
            timer     = TMR_DIGIT;
            countdown = digit_wait_ms;
         end
      endfunction

      function void apply_request(logic [CMD_W-1:0] cmd, logic level);
         int          n_prior;
         dial_event_t ev;
         n_prior = awaited_events.size();
         case (cmd)
            CMD_TICK: tick();
            CMD_DIAL: pin_edge(1'b0, level);
            CMD_HOOK: pin_edge(1'b1, level);
            default: ;
         endcase
         // flag the final event of this request
         if (awaited_events.size() > n_prior) begin
            ev = awaited_events.pop_back();
            ev.last = 1'b1;
            awaited_events.push_back(ev);
         end
      endfunction

      function void check_event(dial_event_t got);
         dial_event_t want;
         n_checked++;
         if (awaited_events.size() == 0) begin
            n_failed++;
            if (n_failed <= 10)
               $display("ERROR: unexpected result kind %0d digit %0d hook %0b length %0d last %0b",
                        got.kind, got.digit, got.hook, got.length, got.last);
            return;
         end
         want = awaited_events.pop_front();
         if (got.kind !== want.kind || got.digit !== want.digit || got.hook !== want.hook ||
             got.length !== want.length || got.last !== want.last) begin
            n_failed++;
            if (n_failed <= 10) begin
               $display("ERROR: result %0d expected kind %0d digit %0d hook %0b length %0d last %0b",
                        n_checked, want.kind, want.digit, want.hook, want.length, want.last);
               $display("ERROR: result %0d actual   kind %0d digit %0d hook %0b length %0d last %0b",
                        n_checked, got.kind, got.digit, got.hook, got.length, got.last);
            end
         end
      endfunction

      function int pending();
         return awaited_events.size();
      endfunction
   endclass

endpackage

// File: tb/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Testbench of the rotary dial pulse decoder. Drives ticks, dial edges and
// hook edges through the request channel, mostly as complete calls with
// random digits plus line noise, across several timing settings and idle
// patterns, and checks every result event against the scoreboard.
// ----------------------------------------------------------------------------

module tb_top;

   import rdpd_pkg::*;
   import rdpd_tb_pkg::*;

   localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;
   localparam int QUIET_CYCLES = 80;
   localparam int STALL_LIMIT  = 2000;
   localparam int LONG_HOLD    = 200;

   logic                 clock         = 1'b0;
   logic                 reset         = 1'b1;
   logic                 csr_write     = 1'b0;
   logic [CSR_IDX_W-1:0] csr_index     = CSR_DEBOUNCE;
   logic [CSR_W-1:0]     csr_wdata     = '0;
   logic                 req_valid     = 1'b0;
   logic                 req_ready;
   logic [CMD_W-1:0]     req_command   = CMD_TICK;
   logic                 req_pin_level = 1'b0;
   logic                 rsp_valid;
   logic                 rsp_ready     = 1'b0;
   logic [KIND_W-1:0]    rsp_event_kind;
   logic [DIGIT_W-1:0]   rsp_digit;
   logic                 rsp_hook_level;
   logic [LEN_W-1:0]     rsp_number_length;
   logic                 rsp_last_of_run;

   dial_scoreboard   sb;
   logic [CSR_W-1:0] cur_db, cur_cg, cur_dt, cur_et;
   int               sender_idle_pct    = 0;
   int               receiver_stall_pct = 0;
   bit               hold_request       = 1'b0;
   int               n_sent             = 0;
   int               quiet_cycles       = 0;

   rotary_dial_pulse_decoder_unit DUT (
      .clock             (clock),
      .reset             (reset),
      .csr_write         (csr_write),
      .csr_index         (csr_index),
      .csr_wdata         (csr_wdata),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_command       (req_command),
      .req_pin_level     (req_pin_level),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_event_kind    (rsp_event_kind),
      .rsp_digit         (rsp_digit),
      .rsp_hook_level    (rsp_hook_level),
      .rsp_number_length (rsp_number_length),
      .rsp_last_of_run   (rsp_last_of_run)
   );

   always #6 clock = ~clock;

   always @(posedge clock) begin : result_monitor
      dial_event_t got;
      if (!reset && rsp_valid && rsp_ready) begin
         got.kind   = rsp_event_kind;
         got.digit  = rsp_digit;
         got.hook   = rsp_hook_level;
         got.length = rsp_number_length;
         got.last   = rsp_last_of_run;
         sb.check_event(got);
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= STALL_LIMIT) begin
         $display("simulation failed");
         $finish;
      end
   end

   // receiver: random stalls, and one long hold-off on request
   initial begin
      forever begin
         @(negedge clock);
         if (hold_request) begin
            hold_request = 1'b0;
            rsp_ready <= 1'b0;
            repeat (LONG_HOLD) @(negedge clock);
         end
         rsp_ready <= ($urandom_range(0, 99) >= receiver_stall_pct);
      end
   end

   // Leaves valid high after acceptance; the next call or drain moves it on.
   task automatic send_request(logic [CMD_W-1:0] cmd, logic level);
      while ($urandom_range(0, 99) < sender_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid     <= 1'b1;
      req_command   <= cmd;
      req_pin_level <= level;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      sb.apply_request(cmd, level);
      n_sent++;
      @(negedge clock);
   endtask

   task automatic ticks(int n);
      repeat (n) send_request(CMD_TICK, 1'b0);
   endtask

   // space edges at or just past the debounce gap
   task automatic space();
      ticks(cur_db + $urandom_range(0, 1));
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      @(negedge clock);
      while (sb.pending() != 0) @(negedge clock);
   endtask

   task automatic settle();
      drain();
      repeat (QUIET_CYCLES) @(negedge clock);
   endtask

   task automatic put_csr(logic [CSR_IDX_W-1:0] idx, logic [CSR_W-1:0] value);
      csr_write <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(negedge clock);
      sb.write_register(idx, value);
   endtask

   task automatic program_timing(logic [CSR_W-1:0] db, logic [CSR_W-1:0] cg,
                                 logic [CSR_W-1:0] dt, logic [CSR_W-1:0] et);
      put_csr(CSR_DEBOUNCE, db);
      put_csr(CSR_COMMIT, cg);
      put_csr(CSR_DIGIT_TO, dt);
      put_csr(CSR_END_TO, et);
      csr_write <= 1'b0;
      cur_db = db;
      cur_cg = cg;
      cur_dt = dt;
      cur_et = et;
   endtask

   // One call: off hook, start, digits as pulse trains, then end or hang up.
   task automatic dial_call(int lo_digits, int hi_digits, int pulse_hi, bit may_hang_up);
      int n_digits, n_pulses, d, p;
      n_digits = $urandom_range(lo_digits, hi_digits);
      if (!sb.hook_off) begin
         space();
         send_request(CMD_HOOK, 1'b1);
      end
      space();
      send_request(CMD_DIAL, 1'b1);
      for (d = 0; d < n_digits; d++) begin
         n_pulses = ($urandom_range(0, 9) == 0) ? $urandom_range(11, 17)
                                                : $urandom_range(1, pulse_hi);
         for (p = 0; p < n_pulses; p++) begin
            space();
            if (p > 0 && $urandom_range(0, 9) < 7) begin
               send_request(CMD_DIAL, 1'b1);
               space();
            end
            send_request(CMD_DIAL, 1'b0);
            // contact bounce
            if ($urandom_range(0, 19) == 0) send_request(CMD_DIAL, 1'($urandom_range(0, 1)));
         end
         if (may_hang_up && $urandom_range(0, 11) == 0) begin
            space();
            send_request(CMD_HOOK, 1'b0);
            return;
         end
         // close the digit by silence or by a late rising edge
         if (cur_dt <= 40 && (cur_cg > 40 || $urandom_range(0, 1) == 1)) begin
            ticks((cur_dt == 0 ? 1 : int'(cur_dt)) + $urandom_range(0, 1));
         end else if (cur_cg <= 40) begin
            ticks((cur_cg > cur_db ? int'(cur_cg) : int'(cur_db)) + $urandom_range(0, 1));
            send_request(CMD_DIAL, 1'b1);
         end
      end
      if (may_hang_up && $urandom_range(0, 3) == 0) begin
         space();
         send_request(CMD_HOOK, 1'b0);
      end else if (cur_et <= 60) begin
         ticks(cur_et + $urandom_range(0, 2));
      end
   endtask

   // Short pulse trains, one tick each to close the digit, one digit past full.
   // Needs no debounce gap and a one tick digit timeout.
   task automatic fill_store();
      int d;
      if (!sb.hook_off) send_request(CMD_HOOK, 1'b1);
      send_request(CMD_DIAL, 1'b1);
      for (d = 0; d <= int'(MAX_DIGITS_DEF); d++) begin
         repeat ($urandom_range(1, 3)) send_request(CMD_DIAL, 1'b0);
         ticks(1);
      end
   endtask

   task automatic run_phase(int quota, int lo_digits, int hi_digits, int pulse_hi);
      int first_item, n;
      first_item = n_sent;
      while ((n_sent - first_item) < quota) begin
         case ($urandom_range(0, 9))
            0, 1: begin
               n = $urandom_range(1, 6);
               repeat (n) begin
                  ticks($urandom_range(0, 3));
                  send_request(2'($urandom_range(0, 3)), 1'($urandom_range(0, 1)));
               end
            end
            2: if ($urandom_range(0, 3) == 0) drain();
            default: dial_call(lo_digits, hi_digits, pulse_hi, 1'b1);
         endcase
      end
   endtask

   initial begin
      sb = new();
      cur_db = DEBOUNCE_RST;
      cur_cg = COMMIT_RST;
      cur_dt = DIGIT_TO_RST;
      cur_et = END_TO_RST;
      repeat (2) @(negedge clock);
      reset <= 1'b0;

      // default debounce: an edge exactly one gap after reset
      ticks(int'(DEBOUNCE_RST));
      send_request(CMD_HOOK, 1'b0);
      settle();

      // directed: unused command, dial edge on hook, bounces, zero digit timeout
      program_timing(16'd2, 16'd3, 16'd0, 16'd1);
      send_request(CMD_UNUSED, 1'b1);
      send_request(CMD_UNUSED, 1'b0);
      ticks(2);
      send_request(CMD_DIAL, 1'b1);
      ticks(2);
      send_request(CMD_HOOK, 1'b1);
      send_request(CMD_HOOK, 1'b1);
      ticks(2);
      send_request(CMD_DIAL, 1'b1);
      send_request(CMD_DIAL, 1'b1);
      ticks(2);
      send_request(CMD_DIAL, 1'b0);
      ticks(2);
      send_request(CMD_DIAL, 1'b1);
      ticks(2);
      send_request(CMD_DIAL, 1'b0);
      ticks(2);
      ticks(2);
      send_request(CMD_HOOK, 1'b0);
      settle();

      // fill the digit store until it overflows; no number end by timer
      program_timing(16'd0, 16'hFFFF, 16'd1, 16'hFFFF);
      fill_store();
      settle();

      sender_idle_pct = 60;
      program_timing(16'd1, 16'd0, 16'd4, 16'd12);
      run_phase(20, 1, 2, 3);
      settle();

      sender_idle_pct    = 0;
      receiver_stall_pct = 60;
      program_timing(16'd1, 16'hFFFF, 16'd5, 16'd15);
      run_phase(20, 1, 2, 3);
      settle();

      // block the result side for a long stretch while requests keep coming
      sender_idle_pct    = 11;
      receiver_stall_pct = 11;
      program_timing(16'd2, 16'd4, 16'd3, 16'd9);
      hold_request = 1'b1;
      dial_call(1, 2, 3, 1'b0);
      run_phase(10, 1, 2, 3);
      settle();

      if (sb.n_failed == 0) $display("simulation ok");
      else $display("simulation failed");
      $finish;
   end

endmodule
